/* sv/tkps_pkg.sv */
// ----------------------------------------------------------------------------
// Token sampler package
// Shared types, register indexes, operation codes and constant tables for the
// top-k / top-p temperature token sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tkps_pkg;

    // Field widths of the transaction payloads and configuration port.
    localparam int LOGIT_W    = 16;
    localparam int TOKEN_W    = 12;
    localparam int KEPT_W     = 13;
    localparam int TOPK_W     = 13;
    localparam int TOPP_W     = 17;
    localparam int TEMP_W     = 16;
    localparam int DRAW_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TOP_K = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_P = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP  = 2'd2;

    // Fixed-point constants.
    localparam logic [TOPP_W-1:0] P_ONE      = 17'd65536;
    localparam logic [16:0]       LOG2E_Q16  = 17'd94548;
    localparam logic [TOPK_W-1:0] TOPK_RESET = 13'd0;
    localparam logic [TEMP_W-1:0] TEMP_RESET = 16'd256;

    // Step counts of the multi-cycle units.
    localparam int DIV_STEPS = 34;
    localparam int EXP_STEPS = 16;
    localparam int MUL_STEPS = 17;

    // Input and output transaction payloads.
    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit_value;
        logic                      is_last;
        logic [DRAW_W-1:0]         uniform_draw;
    } t_in_item;

    typedef struct packed {
        logic [TOKEN_W-1:0] token_index;
        logic [KEPT_W-1:0]  kept_count;
        logic               overflow;
    } t_out_item;

    // Controller states.
    typedef enum logic [3:0] {
        ST_LOAD, ST_SETUP, ST_SCAN, ST_MULT, ST_DIV, ST_EXP, ST_STORE,
        ST_PMUL, ST_PSCAN, ST_DMUL, ST_DSCAN, ST_RESULT
    } t_state;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_LOAD, OP_SETUP, OP_SCAN, OP_MULT, OP_DIV, OP_EXP, OP_STORE,
        OP_PMUL, OP_PSCAN, OP_DMUL, OP_DSCAN, OP_RESULT
    } t_op;

    // Controller to datapath.
    typedef struct packed {
        t_op  op;
        logic first;
        logic take;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic done;
        logic greedy;
        logic use_p;
        logic more;
        logic out_free;
    } t_status;

    typedef logic [15:0][31:0] t_exp_tab;

    // Integer square root of a 64-bit value, used only at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = x;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Table of 2^(-2^-j), j = 1..16, in Q0.32 by repeated square roots.
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    t;
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int i = 0; i < 16; i++) begin
            c = isqrt64(c << 32);
            t[i] = c[31:0];
        end
        return t;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

/* sv/tkps_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tkps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/tkps_ctrl.sv */
// ----------------------------------------------------------------------------
// Token sampler controller
// Sequences loading, ranking, weighting, nucleus cut and the final draw.
// ----------------------------------------------------------------------------
`default_nettype none

module tkps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    input  wire tkps_pkg::t_status i_status,
    output      tkps_pkg::t_cmd    o_cmd,
    output      logic              o_in_ready
);

    import tkps_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_first;

    // State register; the first flag marks the opening cycle of a state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            r_first <= (n_state != r_state);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:   if (i_in_valid && i_in_last) n_state = ST_SETUP;
            ST_SETUP:  n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_status.done) begin
                    n_state = i_status.greedy ? ST_RESULT : ST_MULT;
                end
            end
            ST_MULT:   n_state = ST_DIV;
            ST_DIV:    if (i_status.done) n_state = ST_EXP;
            ST_EXP:    if (i_status.done) n_state = ST_STORE;
            ST_STORE: begin
                if (i_status.more) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = i_status.use_p ? ST_PMUL : ST_DMUL;
                end
            end
            ST_PMUL:   if (i_status.done) n_state = ST_PSCAN;
            ST_PSCAN:  if (i_status.done) n_state = ST_DMUL;
            ST_DMUL:   if (i_status.done) n_state = ST_DSCAN;
            ST_DSCAN:  if (i_status.done) n_state = ST_RESULT;
            ST_RESULT: if (i_status.out_free) n_state = ST_LOAD;
            default:   n_state = ST_LOAD;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_in_ready  = (r_state == ST_LOAD);
        o_cmd.first = r_first;
        o_cmd.take  = o_in_ready && i_in_valid;
        case (r_state)
            ST_LOAD:   o_cmd.op = OP_LOAD;
            ST_SETUP:  o_cmd.op = OP_SETUP;
            ST_SCAN:   o_cmd.op = OP_SCAN;
            ST_MULT:   o_cmd.op = OP_MULT;
            ST_DIV:    o_cmd.op = OP_DIV;
            ST_EXP:    o_cmd.op = OP_EXP;
            ST_STORE:  o_cmd.op = OP_STORE;
            ST_PMUL:   o_cmd.op = OP_PMUL;
            ST_PSCAN:  o_cmd.op = OP_PSCAN;
            ST_DMUL:   o_cmd.op = OP_DMUL;
            ST_DSCAN:  o_cmd.op = OP_DSCAN;
            ST_RESULT: o_cmd.op = OP_RESULT;
            default:   o_cmd.op = OP_LOAD;
        endcase
    end

endmodule

`default_nettype wire

/* sv/tkps_dp.sv */
// ----------------------------------------------------------------------------
// Token sampler datapath
// Logit store, ranking scan, exponent divider and table unit, serial
// multiplier, nucleus and draw scans, configuration and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tkps_dp #(
    parameter int VOCAB_DEPTH = 4096,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tkps_pkg::t_cmd                      i_cmd,
    input  wire tkps_pkg::t_in_item                  i_in_data,
    input  wire logic                                i_cfg_valid,
    input  wire logic [tkps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tkps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output      logic                                o_cfg_ready,
    output      tkps_pkg::t_status                   o_status,
    output      logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    output      tkps_pkg::t_out_item                 o_out_data
);

    import tkps_pkg::*;

    localparam int AW  = $clog2(VOCAB_DEPTH);
    localparam int CW  = $clog2(VOCAB_DEPTH + 1);
    localparam int CTW = (CW > 6) ? CW : 6;
    localparam int KW  = (CW > TOPK_W) ? CW : TOPK_W;
    localparam int WW  = WEIGHT_BITS + 1;
    localparam int SW  = WEIGHT_BITS + 1 + AW;
    localparam int PW  = SW + TOPP_W;
    localparam int NW  = PW - 16;

    // Configuration registers.
    logic [TOPK_W-1:0] r_topk;
    logic [TOPP_W-1:0] r_topp;
    logic [TEMP_W-1:0] r_temp;

    // Loading state.
    logic [CW-1:0]     r_n;
    logic              r_ovf;
    logic [DRAW_W-1:0] r_draw;

    // Setup results.
    logic [CW-1:0]     r_k;
    logic [TOPP_W-1:0] r_p;
    logic              r_usep;
    logic              r_greedy;

    // Scan control and data.
    logic [CTW-1:0]           r_cnt;
    logic                     r_rv;
    logic [AW-1:0]            r_ridx;
    logic signed [LOGIT_W-1:0] rd_logit;
    logic [WW-1:0]            rd_weight;
    logic [AW-1:0]            rd_index;

    // Ranking.
    logic signed [LOGIT_W-1:0] r_bv;
    logic [AW-1:0]             r_bj;
    logic                      r_bfound;
    logic signed [LOGIT_W-1:0] r_pv;
    logic [AW-1:0]             r_pj;
    logic                      r_hasprev;
    logic signed [LOGIT_W-1:0] r_mx;
    logic [CW-1:0]             r_t;
    logic [SW-1:0]             r_total;

    // Exponent and weight units.
    logic [DIV_STEPS-1:0] r_num;
    logic [TEMP_W-1:0]    r_rem;
    logic [32:0]          r_m;
    logic [15:0]          r_f;
    logic [17:0]          r_ip;

    // Serial multiplier.
    logic [PW-1:0]     r_acc;
    logic [PW-1:0]     r_mcand;
    logic [TOPP_W-1:0] r_mplier;

    // Nucleus and draw scans.
    logic [SW-1:0] r_run;
    logic          r_found;
    logic [CW-1:0] r_keep;
    logic [SW-1:0] r_ktotal;
    logic [AW-1:0] r_tok;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    // Combinational helpers.
    logic                      take;
    logic                      store_ok;
    logic [CW-1:0]             keep_eff;
    logic [CW-1:0]             lim;
    logic                      issue;
    logic                      scan_done;
    logic signed [LOGIT_W-1:0] mx_now;
    logic signed [LOGIT_W:0]   dsub;
    logic [32:0]               mprod;
    logic [TEMP_W:0]           div_tmp;
    logic                      div_ge;
    logic [64:0]               eprod;
    logic [64:0]               eround;
    logic [18:0]               shamt;
    logic [33:0]               wround;
    logic [33:0]               wshift;
    logic [WW-1:0]             weight;
    logic [SW-1:0]             run_next;
    logic [NW-1:0]             need;
    logic [NW-1:0]             thr;
    logic                      out_free;
    logic [KW-1:0]             k_wide;
    logic [KW-1:0]             n_wide;

    assign o_cfg_ready = 1'b1;
    assign take        = i_cmd.take;
    assign store_ok    = (r_n < CW'(VOCAB_DEPTH));
    assign keep_eff    = r_usep ? r_keep : r_k;
    assign out_free    = !r_out_valid || i_out_ready;

    // Memories.
    tkps_ram #(.WIDTH(LOGIT_W), .DEPTH(VOCAB_DEPTH)) u_logit_ram (
        .i_clk   (i_clk),
        .i_we    (take && store_ok),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (i_in_data.logit_value),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rd_logit)
    );

    tkps_ram #(.WIDTH(WW), .DEPTH(VOCAB_DEPTH)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_STORE),
        .i_waddr (r_t[AW-1:0]),
        .i_wdata (weight),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rd_weight)
    );

    tkps_ram #(.WIDTH(AW), .DEPTH(VOCAB_DEPTH)) u_index_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_STORE),
        .i_waddr (r_t[AW-1:0]),
        .i_wdata (r_pj),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rd_index)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topk <= TOPK_RESET;
            r_topp <= P_ONE;
            r_temp <= TEMP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TOP_K: r_topk <= i_cfg_data[TOPK_W-1:0];
                REG_TOP_P: r_topp <= i_cfg_data[TOPP_W-1:0];
                REG_TEMP:  r_temp <= i_cfg_data[TEMP_W-1:0];
                default:   ;
            endcase
        end
    end

    // Load counter and overflow flag; both clear when a result is issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.op == OP_RESULT && out_free) begin
            r_n   <= '0;
            r_ovf <= 1'b0;
        end else if (take) begin
            if (store_ok) begin
                r_n <= r_n + CW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_data.is_last) begin
            r_draw <= i_in_data.uniform_draw;
        end
    end

    // Effective top-k and top-p.
    assign k_wide = KW'(r_topk);
    assign n_wide = KW'(r_n);

    always_ff @(posedge i_clk) begin
        logic [CW-1:0]     k_c;
        logic [TOPP_W-1:0] p_c;
        if (i_cmd.op == OP_SETUP) begin
            k_c = (r_topk == '0 || k_wide > n_wide) ? r_n : r_topk[CW-1:0];
            p_c = (r_topp == '0 || r_topp > P_ONE) ? P_ONE : r_topp;
            r_k      <= k_c;
            r_p      <= p_c;
            r_usep   <= (p_c != P_ONE);
            r_greedy <= (r_temp == '0) || (k_c == CW'(1) && p_c == P_ONE);
        end
    end

    // Scan sequencing over the memories; read data arrives in the cycle after its address.
    always_comb begin
        case (i_cmd.op)
            OP_SCAN:  lim = r_n;
            OP_PSCAN: lim = r_k;
            OP_DSCAN: lim = keep_eff;
            default:  lim = '0;
        endcase
    end

    assign issue     = !i_cmd.first && (r_cnt < CTW'(lim));
    assign scan_done = !i_cmd.first && (r_cnt == CTW'(lim)) && !r_rv;

    // Shared step counter and read pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rv  <= 1'b0;
        end else begin
            r_rv   <= 1'b0;
            r_ridx <= r_cnt[AW-1:0];
            if (i_cmd.first) begin
                r_cnt <= '0;
            end else begin
                case (i_cmd.op)
                    OP_SCAN, OP_PSCAN, OP_DSCAN: begin
                        if (issue) begin
                            r_cnt <= r_cnt + CTW'(1);
                            r_rv  <= 1'b1;
                        end
                    end
                    OP_DIV: if (r_cnt < CTW'(DIV_STEPS)) r_cnt <= r_cnt + CTW'(1);
                    OP_EXP: if (r_cnt < CTW'(EXP_STEPS)) r_cnt <= r_cnt + CTW'(1);
                    OP_PMUL, OP_DMUL: begin
                        if (r_cnt < CTW'(MUL_STEPS)) r_cnt <= r_cnt + CTW'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    // Ranking pass: best entry that comes after the previous pick in
    // descending order, ties going to the lower index.
    always_ff @(posedge i_clk) begin
        logic elig;
        if (i_cmd.op == OP_SETUP) begin
            r_hasprev <= 1'b0;
        end else if (i_cmd.op == OP_SCAN) begin
            if (i_cmd.first) begin
                r_bfound <= 1'b0;
            end else if (r_rv) begin
                elig = !r_hasprev || (rd_logit < r_pv) ||
                       (rd_logit == r_pv && r_ridx > r_pj);
                if (elig && (!r_bfound || rd_logit > r_bv)) begin
                    r_bv     <= rd_logit;
                    r_bj     <= r_ridx;
                    r_bfound <= 1'b1;
                end
            end
        end else if (i_cmd.op == OP_MULT) begin
            if (r_t == '0) begin
                r_mx <= r_bv;
            end
            r_pv      <= r_bv;
            r_pj      <= r_bj;
            r_hasprev <= 1'b1;
        end
    end

    // Exponent numerator: (max - logit) * log2(e) plus half the temperature.
    assign mx_now = (r_t == '0) ? r_bv : r_mx;
    assign dsub   = {mx_now[LOGIT_W-1], mx_now} - {r_bv[LOGIT_W-1], r_bv};
    assign mprod  = 33'(dsub[LOGIT_W-1:0]) * 33'(LOG2E_Q16);

    // Restoring divider step.
    assign div_tmp = {r_rem, r_num[DIV_STEPS-1]};
    assign div_ge  = (div_tmp >= {1'b0, r_temp});

    // Fraction step through the root table.
    assign eprod  = 65'(r_m) * 65'(EXP_TAB[r_cnt[3:0]]);
    assign eround = eprod + (65'd1 << 31);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MULT: r_num <= 34'(mprod) + 34'(r_temp[TEMP_W-1:1]);
            OP_DIV: begin
                if (i_cmd.first) begin
                    r_rem <= '0;
                end else if (r_cnt < CTW'(DIV_STEPS)) begin
                    if (div_ge) begin
                        r_rem <= TEMP_W'(div_tmp - {1'b0, r_temp});
                        r_num <= {r_num[DIV_STEPS-2:0], 1'b1};
                    end else begin
                        r_rem <= div_tmp[TEMP_W-1:0];
                        r_num <= {r_num[DIV_STEPS-2:0], 1'b0};
                    end
                end
            end
            OP_EXP: begin
                if (i_cmd.first) begin
                    r_m  <= 33'h1_0000_0000;
                    r_f  <= r_num[15:0];
                    r_ip <= r_num[DIV_STEPS-1:16];
                end else if (r_cnt < CTW'(EXP_STEPS)) begin
                    if (r_f[15]) begin
                        r_m <= eround[64:32];
                    end
                    r_f <= {r_f[14:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // Final weight: scale to the weight format with round to nearest.
    assign shamt  = 19'(32 - WEIGHT_BITS) + {1'b0, r_ip};
    assign wround = {1'b0, r_m} + ((shamt[5:0] == 6'd0) ? 34'd0 :
                    (34'd1 << (shamt[5:0] - 6'd1)));
    assign wshift = wround >> shamt[5:0];

    always_comb begin
        if (r_ip >= 18'd64 || shamt >= 19'd40) begin
            weight = '0;
        end else if (shamt == 19'd0) begin
            weight = WW'(r_m);
        end else begin
            weight = WW'(wshift);
        end
    end

    // Pick counter and running total of the kept weights.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SETUP) begin
            r_t     <= '0;
            r_total <= '0;
        end else if (i_cmd.op == OP_STORE) begin
            r_t     <= r_t + CW'(1);
            r_total <= r_total + SW'(weight);
        end
    end

    // Serial shift-and-add multiplier for the share and draw thresholds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PMUL || i_cmd.op == OP_DMUL) begin
            if (i_cmd.first) begin
                r_acc <= '0;
                if (i_cmd.op == OP_PMUL) begin
                    r_mcand  <= PW'(r_total);
                    r_mplier <= r_p;
                end else begin
                    r_mcand  <= PW'(r_usep ? r_ktotal : r_total);
                    r_mplier <= TOPP_W'(r_draw);
                end
            end else if (r_cnt < CTW'(MUL_STEPS)) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[PW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[TOPP_W-1:1]};
            end
        end
    end

    assign thr      = r_acc[PW-1:16];
    assign need     = thr + NW'(|r_acc[15:0]);
    assign run_next = r_run + SW'(rd_weight);

    // Nucleus cut and weighted draw over the ranked weights.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PSCAN || i_cmd.op == OP_DSCAN) begin
            if (i_cmd.first) begin
                r_run   <= '0;
                r_found <= 1'b0;
            end else if (r_rv) begin
                r_run <= run_next;
                if (!r_found) begin
                    if (i_cmd.op == OP_PSCAN) begin
                        if (NW'(run_next) >= need) begin
                            r_found  <= 1'b1;
                            r_keep   <= CW'(r_ridx) + CW'(1);
                            r_ktotal <= run_next;
                        end
                    end else begin
                        r_tok <= rd_index;
                        if (NW'(run_next) > thr) begin
                            r_found <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_RESULT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RESULT && out_free) begin
            r_out.token_index <= TOKEN_W'(r_greedy ? r_bj : r_tok);
            r_out.kept_count  <= r_greedy ? KEPT_W'(1) : KEPT_W'(keep_eff);
            r_out.overflow    <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status to the controller.
    always_comb begin
        case (i_cmd.op)
            OP_SCAN, OP_PSCAN, OP_DSCAN: o_status.done = scan_done;
            OP_DIV:  o_status.done = !i_cmd.first && (r_cnt == CTW'(DIV_STEPS));
            OP_EXP:  o_status.done = !i_cmd.first && (r_cnt == CTW'(EXP_STEPS));
            OP_PMUL, OP_DMUL: begin
                o_status.done = !i_cmd.first && (r_cnt == CTW'(MUL_STEPS));
            end
            default: o_status.done = 1'b0;
        endcase
        o_status.greedy   = r_greedy;
        o_status.use_p    = r_usep;
        o_status.more     = (r_t + CW'(1)) < r_k;
        o_status.out_free = out_free;
    end

endmodule

`default_nettype wire

/* sv/top_k_top_p_token_sampler.sv */
// Loading takes one logit per cycle; the item marked last starts sampling.
// Greedy path: the result is offered after one logit memory scan.
// Sampling path: one full logit scan per ranked candidate plus the serial divider and table
// unit; then the serial multiplier and nucleus cut scan when top-p is below one, and the multiplier
// and draw scan; a stalled result adds its wait, and one vocabulary is handled at a time.
// Reset is synchronous, active low; memories are not cleared.
// ----------------------------------------------------------------------------
// Top-k / top-p temperature token sampler
// Streams signed Q8.8 logits and returns one sampled token index per
// vocabulary.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_top_p_token_sampler #(
    parameter int VOCAB_DEPTH = 4096,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire tkps_pkg::t_in_item              i_in_data,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output      tkps_pkg::t_out_item             o_out_data,
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [tkps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tkps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import tkps_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    tkps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.is_last),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    // Storage and arithmetic.
    tkps_dp #(
        .VOCAB_DEPTH (VOCAB_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* sv/tkps_checker.sv */
// ----------------------------------------------------------------------------
// Token sampler port checker
// Port-level assertions on the sampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tkps_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire tkps_pkg::t_in_item  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire tkps_pkg::t_out_item o_out_data
);

    // A pending result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before its transaction completed");

    // A pending result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // The last logit closes the input until sampling has finished.
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.is_last |=> !o_in_ready)
        else $error("input accepted right after the last logit");

    // A new result is only issued when the input side was closed.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while loading");

endmodule

bind top_k_top_p_token_sampler tkps_checker u_tkps_checker (.*);

`default_nettype wire

/* verif/tkps_sample_checker.sv */
// ----------------------------------------------------------------------------
// Token sampler checker
// Watches the configuration, logit and result channels of the token sampler,
// predicts every sampled token from its own copy of the registers and the
// logit store, and compares each result transaction with the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tkps_sample_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_ready,
    input  wire tkps_pkg::t_in_item              i_in_data,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_ready,
    input  wire tkps_pkg::t_out_item             i_out_data,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [tkps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tkps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_checked
);

    import tkps_pkg::*;

    localparam int STORE_DEPTH = 4096;

    // Shadow registers.
    logic [TOPK_W-1:0] topk_reg;
    logic [TOPP_W-1:0] topp_reg;
    logic [TEMP_W-1:0] temp_reg;

    // Shadow of the vocabulary being loaded.
    logic signed [LOGIT_W-1:0] logits [STORE_DEPTH];
    int unsigned               ranked [STORE_DEPTH];
    longint unsigned           weights [STORE_DEPTH];
    int unsigned               load_cnt;
    bit                        dropped;

    longint unsigned root_tab [16];
    t_out_item       token_q [$];

    // Bitwise integer square root of a 64-bit value.
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Weight 2^(-d * log2(e) / T) in Q1.16 for a distance d below the maximum.
    function automatic longint unsigned exp_weight(int unsigned d);
        longint unsigned e;
        longint unsigned ip;
        longint unsigned m;
        longint unsigned s;
        e = (longint'(d) * 94548 + (temp_reg >> 1)) / temp_reg;
        ip = e >> 16;
        m = 64'd1 << 32;
        if (ip >= 64) return 0;
        for (int b = 0; b < 16; b++) begin
            if (e[15-b]) m = (m * root_tab[b] + (64'd1 << 31)) >> 32;
        end
        s = 16 + ip;
        if (s >= 40) return 0;
        return (m + (64'd1 << (s - 1))) >> s;
    endfunction

    // Chooses the token of the loaded vocabulary and its survivor count.
    function automatic void choose_token(input int unsigned n, input int unsigned draw,
                                         output int unsigned tok,
                                         output int unsigned kept);
        int unsigned     k;
        int unsigned     p;
        int unsigned     keep;
        int unsigned     j;
        longint unsigned total;
        longint unsigned run;
        longint unsigned need;
        longint unsigned thr;
        k = topk_reg;
        p = topp_reg;
        if (k == 0 || k > n) k = n;
        if (p == 0 || p > 65536) p = 65536;
        kept = 1;
        // Greedy: the first maximum wins.
        if (temp_reg == 0 || (k == 1 && p == 65536)) begin
            tok = 0;
            for (int i = 1; i < n; i++) if (logits[i] > logits[tok]) tok = i;
            return;
        end
        // Stable descending rank, ties to the lower index.
        for (int i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && logits[ranked[j-1]] < logits[i]) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = i;
        end
        total = 0;
        for (int i = 0; i < k; i++) begin
            weights[i] = exp_weight(int'(logits[ranked[0]]) - int'(logits[ranked[i]]));
            total += weights[i];
        end
        // Nucleus cut: shortest prefix reaching ceil(total * p).
        keep = k;
        if (p < 65536) begin
            need = (total * p + 65535) >> 16;
            run = 0;
            for (int i = 0; i < k; i++) begin
                run += weights[i];
                if (run >= need) begin
                    keep = i + 1;
                    break;
                end
            end
        end
        total = 0;
        for (int i = 0; i < keep; i++) total += weights[i];
        thr = (total * draw) >> 16;
        kept = keep;
        run = 0;
        tok = ranked[keep-1];
        for (int i = 0; i < keep; i++) begin
            run += weights[i];
            if (run > thr) begin
                tok = ranked[i];
                break;
            end
        end
    endfunction

    initial begin
        longint unsigned c;
        c = 64'd1 << 31;
        for (int i = 0; i < 16; i++) begin
            c = int_sqrt(c << 32);
            root_tab[i] = c;
        end
    end

    assign o_pending = token_q.size();

    // Track every transaction on the three channels.
    always @(posedge i_clk) begin
        int unsigned tok;
        int unsigned kept;
        t_out_item   want;
        if (!i_rst_n) begin
            topk_reg     = TOPK_RESET;
            topp_reg     = P_ONE;
            temp_reg     = TEMP_RESET;
            load_cnt     = 0;
            dropped      = 0;
            o_fail_count = 0;
            o_checked    = 0;
            token_q.delete();
        end else begin
            // Result transaction: compare with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (token_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected result token=%0d kept=%0d ovf=%0b",
                                 i_out_data.token_index, i_out_data.kept_count,
                                 i_out_data.overflow);
                end else begin
                    want = token_q.pop_front();
                    if (i_out_data.token_index !== want.token_index ||
                        i_out_data.kept_count !== want.kept_count ||
                        i_out_data.overflow !== want.overflow) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"ERROR: result mismatch: expected token=%0d ",
                                      "kept=%0d ovf=%0b, got token=%0d kept=%0d ovf=%0b"},
                                     want.token_index, want.kept_count, want.overflow,
                                     i_out_data.token_index, i_out_data.kept_count,
                                     i_out_data.overflow);
                    end
                end
            end
            // Register write.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TOP_K: topk_reg = i_cfg_data[TOPK_W-1:0];
                    REG_TOP_P: topp_reg = i_cfg_data[TOPP_W-1:0];
                    REG_TEMP:  temp_reg = i_cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
            // Logit transaction: store it, and predict on the last one.
            if (i_in_valid && i_in_ready) begin
                if (load_cnt < STORE_DEPTH) begin
                    logits[load_cnt] = i_in_data.logit_value;
                    load_cnt++;
                end else begin
                    dropped = 1;
                end
                if (i_in_data.is_last) begin
                    choose_token(load_cnt, i_in_data.uniform_draw, tok, kept);
                    want.token_index = tok[TOKEN_W-1:0];
                    want.kept_count  = kept[KEPT_W-1:0];
                    want.overflow    = dropped;
                    token_q.push_back(want);
                    load_cnt = 0;
                    dropped  = 0;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* verif/top_k_top_p_token_sampler_test.sv */
// ----------------------------------------------------------------------------
// Token sampler testbench
// Streams vocabularies of logits through the sampler under a series of
// top-k, top-p and temperature settings, with bursty input and a stalling
// result side; a checker beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_top_p_token_sampler_test;
    import tkps_pkg::*;

    localparam int IDLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS = 1860;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int burst_left;
    int vocab_cnt;
    int item_cnt;
    int idle_cycles;
    int rx_left;
    int rx_mode;

    top_k_top_p_token_sampler u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tkps_sample_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock.
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: stall pattern that switches mode every so often.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (rx_left % 24 < 4);
        endcase
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles", IDLE_LIMIT);
            $display("FAIL top_k_top_p_token_sampler");
            $finish;
        end
    end

    // Send one logit transaction, then maybe pause before the next one.
    task automatic send_logit(input logic signed [LOGIT_W-1:0] value, input bit last,
                              input logic [DRAW_W-1:0] draw);
        int gap;
        in_valid <= 1'b1;
        in_data.logit_value  <= value;
        in_data.is_last      <= last;
        in_data.uniform_draw <= draw;
        do @(posedge clk); while (!in_ready);
        item_cnt++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            in_data  <= t_in_item'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until the block has delivered everything and gone quiet.
    task automatic settle();
        if (in_valid) in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // One register write transaction.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int unsigned k, input int unsigned p, input int unsigned t);
        settle();
        set_reg(REG_TOP_K, k);
        set_reg(REG_TOP_P, p);
        set_reg(REG_TEMP, t);
    endtask

    // Logit of a given flavor: wide random, clustered, tied or at the rails.
    function automatic logic signed [LOGIT_W-1:0] make_logit(int flavor, int base);
        int v;
        case (flavor)
            0:       v = $signed(16'($urandom));
            1:       v = base + int'($urandom_range(0, 1200)) - 600;
            2:       v = base + 64 * int'($urandom_range(0, 2));
            default: v = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                              : -32768 + $urandom_range(0, 3);
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[LOGIT_W-1:0];
    endfunction

    // One whole vocabulary of n logits.
    task automatic send_vocab(input int n);
        int flavor;
        int base;
        flavor = $urandom_range(0, 3);
        base   = int'($urandom_range(0, 60000)) - 30000;
        for (int i = 0; i < n; i++)
            send_logit(make_logit(flavor, base), i == n - 1, 16'($urandom));
        vocab_cnt++;
    endtask

    initial begin
        int unsigned k;
        int unsigned p;
        int unsigned t;
        int          start_items;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_TOP_K;
        cfg_data   = '0;
        burst_left = 0;
        vocab_cnt  = 0;
        item_cnt   = 0;
        idle_cycles = 0;
        rx_left    = 0;
        rx_mode    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, rails, ties, extreme draws, single logit.
        send_logit(16'sh7FFF, 1'b0, 16'h0);
        send_logit(-16'sh8000, 1'b0, 16'h0);
        send_logit(16'sh7FFF, 1'b1, 16'hFFFF);
        vocab_cnt++;
        send_logit(16'sh0100, 1'b0, 16'h0);
        send_logit(16'sh0100, 1'b0, 16'h0);
        send_logit(16'sh00C0, 1'b1, 16'h0000);
        vocab_cnt++;
        send_logit(16'sh0100, 1'b0, 16'h0);
        send_logit(16'sh0100, 1'b0, 16'h0);
        send_logit(16'sh00C0, 1'b1, 16'hFFFF);
        vocab_cnt++;
        send_logit(-16'sh0001, 1'b1, 16'h8000);
        vocab_cnt++;
        // Greedy by zero temperature, first maximum wins.
        configure(0, 65536, 0);
        send_logit(-16'sh0200, 1'b0, 16'h0);
        send_logit(16'sh0300, 1'b0, 16'h0);
        send_logit(16'sh0300, 1'b1, 16'hFFFF);
        vocab_cnt++;
        // Greedy by top-k of one; then top-k one with a nucleus below one.
        configure(1, 65536, 256);
        send_vocab(5);
        configure(1, 30000, 256);
        send_vocab(5);
        // Out-of-range top-k and top-p, extreme temperatures.
        configure(8191, 131071, 65535);
        send_vocab(6);
        configure(4096, 0, 1);
        send_vocab(6);
        configure(3, 1, 512);
        send_vocab(6);
        // An unused register index must change nothing.
        settle();
        set_reg(2'd3, $urandom);

        // Random phases of settings, each with several vocabularies.
        start_items = item_cnt;
        while (item_cnt - start_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       k = $urandom_range(0, 8191);
                1:       k = 0;
                default: k = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 4))
                0:       p = 65536;
                1:       p = $urandom_range(0, 131071);
                2:       p = $urandom_range(0, 1) ? 1 : 65535;
                default: p = $urandom_range(1000, 65535);
            endcase
            case ($urandom_range(0, 5))
                0:       t = 0;
                1:       t = $urandom_range(0, 1) ? 1 : 65535;
                2:       t = $urandom_range(0, 65535);
                default: t = $urandom_range(16, 1024);
            endcase
            configure(k, p, t);
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 9) == 0)
                    send_vocab($urandom_range(40, 64));
                else
                    send_vocab($urandom_range(1, 16));
            end
        end

        settle();
        repeat (100) @(posedge clk);
        $display("Covered %0d vocabularies, %0d logits, %0d results checked.",
                 vocab_cnt, item_cnt, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS top_k_top_p_token_sampler");
        end else begin
            $display("Mismatches: %0d, results still expected: %0d", fail_count, pending);
            $display("FAIL top_k_top_p_token_sampler");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* top_k_top_p_token_sampler.f */
sv/tkps_pkg.sv
sv/tkps_ram.sv
sv/tkps_ctrl.sv
sv/tkps_dp.sv
sv/top_k_top_p_token_sampler.sv
sv/tkps_checker.sv
verif/tkps_sample_checker.sv
verif/top_k_top_p_token_sampler_test.sv
